FILE: rtl/alle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alle_pkg: shared types and constants of the array linked list engine
// Sizes of the node pool, command and status codes, and the structs that
// travel between the front queue, the list engine and the result queue.
// ----------------------------------------------------------------------------
package alle_pkg;

  // Node pool geometry
  localparam int NODE_COUNT  = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(NODE_COUNT);
  localparam int LINK_W      = $clog2(NODE_COUNT + 1);
  localparam int CNT_W       = LINK_W;

  // Port field widths
  localparam int CMD_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // Null link: one past the last node
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODE_COUNT);

  // Decoupling queues (depth is a power of two)
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Raw command codes on the input port
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_UNDEF  = 2'd3
  } cmd_e;

  // Operation after classification in the front
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_SEARCH,
    OP_NONE
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // List engine states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_INS,
    BK_DEL,
    BK_SRCH
  } back_state_e;

  // Classified command handed to the engine
  typedef struct packed {
    op_e                    op;
    logic [VALUE_WIDTH-1:0] value;
  } cmd_t;

  // Front to engine request
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fe_req_t;

  // One result item
  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } res_t;

  // Sign-extend or truncate input data into the stored value width
  function automatic logic [VALUE_WIDTH-1:0] to_value(input logic signed [DATA_W-1:0] d);
    return VALUE_WIDTH'(d);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/alle_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alle_front: command intake
// Accepts commands, decodes them into operations and holds them in a short
// queue until the list engine takes them.
// ----------------------------------------------------------------------------
module alle_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            push,
  output logic                           full,
  input  wire  [alle_pkg::CMD_W-1:0]     cmd_i,
  input  wire  [alle_pkg::DATA_W-1:0]    data_value_i,
  output alle_pkg::fe_req_t              req_o,
  input  wire                            take_i
);

  alle_pkg::cmd_t                entry_q [alle_pkg::Q_DEPTH];
  alle_pkg::cmd_t                new_cmd;
  logic [alle_pkg::Q_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [alle_pkg::Q_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [alle_pkg::Q_CNT_W-1:0]  cnt_q, cnt_d;
  logic                          wr_en, rd_en;

  // Classify the raw command
  always_comb begin
    new_cmd.value = alle_pkg::to_value(data_value_i);
    case (alle_pkg::cmd_e'(cmd_i))
      alle_pkg::CMD_INSERT: new_cmd.op = alle_pkg::OP_INSERT;
      alle_pkg::CMD_DELETE: new_cmd.op = alle_pkg::OP_DELETE;
      alle_pkg::CMD_SEARCH: new_cmd.op = alle_pkg::OP_SEARCH;
      default:              new_cmd.op = alle_pkg::OP_NONE;
    endcase
  end

  // Queue control
  assign full          = (cnt_q == alle_pkg::Q_CNT_W'(alle_pkg::Q_DEPTH));
  assign wr_en         = push && !full;
  assign req_o.valid   = (cnt_q != '0);
  assign req_o.cmd     = entry_q[rd_ptr_q];
  assign rd_en         = take_i && req_o.valid;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + alle_pkg::Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + alle_pkg::Q_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + alle_pkg::Q_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - alle_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/alle_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alle_back: list engine
// Owns the value and link stores, the list and free heads and the element
// count. Executes one command at a time; search follows one link per cycle.
// ----------------------------------------------------------------------------
module alle_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  alle_pkg::fe_req_t    req_i,
  output logic                 take_o,
  input  wire                  res_full_i,
  output logic                 res_push_o,
  output alle_pkg::res_t       res_o
);

  localparam int NC = alle_pkg::NODE_COUNT;
  localparam int IW = alle_pkg::IDX_W;
  localparam int LW = alle_pkg::LINK_W;
  localparam int CW = alle_pkg::CNT_W;
  localparam int VW = alle_pkg::VALUE_WIDTH;

  // Stores
  logic [VW-1:0] value_mem [NC];
  logic [LW-1:0] link_mem  [NC];
  logic [NC-1:0] link_valid_q;

  // Store ports
  logic          lk_rd_en, lk_wr_en, vl_rd_en, vl_wr_en;
  logic [IW-1:0] lk_rd_addr, lk_wr_addr, vl_rd_addr, vl_wr_addr;
  logic [LW-1:0] lk_wr_data, lk_rdata_q;
  logic [VW-1:0] vl_wr_data, vl_rdata_q;

  // Engine state
  alle_pkg::back_state_e state_q, state_d;
  logic [LW-1:0] list_head_q, list_head_d;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] node_q, node_d;
  logic [LW-1:0] steps_q, steps_d;
  logic [VW-1:0] val_q, val_d;

  // Next state, store control and result
  always_comb begin
    state_d     = state_q;
    list_head_d = list_head_q;
    free_head_d = free_head_q;
    count_d     = count_q;
    node_d      = node_q;
    steps_d     = steps_q;
    val_d       = val_q;
    take_o      = 1'b0;
    res_push_o  = 1'b0;
    res_o.status = alle_pkg::ST_OK;
    res_o.idx    = '0;
    res_o.count  = count_q;
    lk_rd_en    = 1'b0;
    lk_rd_addr  = '0;
    lk_wr_en    = 1'b0;
    lk_wr_addr  = node_q;
    lk_wr_data  = '0;
    vl_rd_en    = 1'b0;
    vl_rd_addr  = '0;
    vl_wr_en    = 1'b0;
    vl_wr_addr  = node_q;
    vl_wr_data  = val_q;

    case (state_q)
      alle_pkg::BK_IDLE: begin
        if (req_i.valid && !res_full_i) begin
          take_o = 1'b1;
          val_d  = req_i.cmd.value;
          case (req_i.cmd.op)
            alle_pkg::OP_INSERT: begin
              if (free_head_q >= alle_pkg::NULL_LINK) begin
                res_push_o   = 1'b1;
                res_o.status = alle_pkg::ST_OVERFLOW;
              end else begin
                lk_rd_en   = 1'b1;
                lk_rd_addr = free_head_q[IW-1:0];
                node_d     = free_head_q[IW-1:0];
                state_d    = alle_pkg::BK_INS;
              end
            end
            alle_pkg::OP_DELETE: begin
              if (list_head_q >= alle_pkg::NULL_LINK) begin
                res_push_o   = 1'b1;
                res_o.status = alle_pkg::ST_UNDERFLOW;
              end else begin
                lk_rd_en   = 1'b1;
                lk_rd_addr = list_head_q[IW-1:0];
                node_d     = list_head_q[IW-1:0];
                state_d    = alle_pkg::BK_DEL;
              end
            end
            alle_pkg::OP_SEARCH: begin
              if (list_head_q >= alle_pkg::NULL_LINK) begin
                res_push_o   = 1'b1;
                res_o.status = alle_pkg::ST_NOTFOUND;
              end else begin
                lk_rd_en   = 1'b1;
                lk_rd_addr = list_head_q[IW-1:0];
                vl_rd_en   = 1'b1;
                vl_rd_addr = list_head_q[IW-1:0];
                node_d     = list_head_q[IW-1:0];
                steps_d    = LW'(1);
                state_d    = alle_pkg::BK_SRCH;
              end
            end
            default: begin
              // undefined command: no change, plain status
              res_push_o = 1'b1;
            end
          endcase
        end
      end

      // Take the free head node and link it in front of the list
      alle_pkg::BK_INS: begin
        free_head_d = lk_rdata_q;
        vl_wr_en    = 1'b1;
        lk_wr_en    = 1'b1;
        lk_wr_data  = list_head_q;
        list_head_d = LW'(node_q);
        count_d     = count_q + CW'(1);
        res_push_o  = 1'b1;
        res_o.idx   = node_q;
        res_o.count = count_d;
        state_d     = alle_pkg::BK_IDLE;
      end

      // Unlink the list head and return it to the free list
      alle_pkg::BK_DEL: begin
        list_head_d = lk_rdata_q;
        lk_wr_en    = 1'b1;
        lk_wr_data  = free_head_q;
        free_head_d = LW'(node_q);
        if (count_q != '0) begin
          count_d = count_q - CW'(1);
        end
        res_push_o  = 1'b1;
        res_o.idx   = node_q;
        res_o.count = count_d;
        state_d     = alle_pkg::BK_IDLE;
      end

      // Data of node_q is in the read registers; compare and follow the link
      alle_pkg::BK_SRCH: begin
        if (vl_rdata_q == val_q) begin
          res_push_o = 1'b1;
          res_o.idx  = node_q;
          state_d    = alle_pkg::BK_IDLE;
        end else if (lk_rdata_q >= alle_pkg::NULL_LINK || steps_q == LW'(NC)) begin
          res_push_o   = 1'b1;
          res_o.status = alle_pkg::ST_NOTFOUND;
          state_d      = alle_pkg::BK_IDLE;
        end else begin
          lk_rd_en   = 1'b1;
          lk_rd_addr = lk_rdata_q[IW-1:0];
          vl_rd_en   = 1'b1;
          vl_rd_addr = lk_rdata_q[IW-1:0];
          node_d     = lk_rdata_q[IW-1:0];
          steps_d    = steps_q + LW'(1);
        end
      end

      default: begin
        state_d = alle_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= alle_pkg::BK_IDLE;
      list_head_q  <= alle_pkg::NULL_LINK;
      free_head_q  <= '0;
      count_q      <= '0;
      link_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      list_head_q <= list_head_d;
      free_head_q <= free_head_d;
      count_q     <= count_d;
      if (lk_wr_en) begin
        link_valid_q[lk_wr_addr] <= 1'b1;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    steps_q <= steps_d;
    val_q   <= val_d;
  end

  // Link store; an entry never written reads as its reset link (index plus one)
  always_ff @(posedge clk_i) begin
    if (lk_wr_en) begin
      link_mem[lk_wr_addr] <= lk_wr_data;
    end
    if (lk_rd_en) begin
      lk_rdata_q <= link_valid_q[lk_rd_addr] ? link_mem[lk_rd_addr]
                                             : LW'(lk_rd_addr) + LW'(1);
    end
  end

  // Value store
  always_ff @(posedge clk_i) begin
    if (vl_wr_en) begin
      value_mem[vl_wr_addr] <= vl_wr_data;
    end
    if (vl_rd_en) begin
      vl_rdata_q <= value_mem[vl_rd_addr];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NC))
    else $error("element count above pool size");

  a_head_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (list_head_q == alle_pkg::NULL_LINK) == (count_q == '0))
    else $error("list head and element count disagree");

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == alle_pkg::BK_INS |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not advance the count");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == alle_pkg::BK_SRCH |-> (steps_q != '0 && steps_q <= LW'(NC)))
    else $error("search walk out of bounds");
`endif

endmodule
`default_nettype wire

FILE: rtl/alle_result_q.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alle_result_q: result queue
// Holds finished results until the consumer pops them, so the engine can
// move on while a result waits.
// ----------------------------------------------------------------------------
module alle_result_q (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                res_push_i,
  input  alle_pkg::res_t                     res_i,
  output logic                               res_full_o,
  output logic                               empty,
  input  wire                                pop,
  output logic [alle_pkg::STATUS_W-1:0]      status_o,
  output logic [alle_pkg::IDX_W-1:0]         node_index_o,
  output logic [alle_pkg::CNT_W-1:0]         element_count_o
);

  alle_pkg::res_t                entry_q [alle_pkg::Q_DEPTH];
  alle_pkg::res_t                head;
  logic [alle_pkg::Q_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [alle_pkg::Q_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [alle_pkg::Q_CNT_W-1:0]  cnt_q, cnt_d;
  logic                          wr_en, rd_en;

  // Queue control
  assign res_full_o = (cnt_q == alle_pkg::Q_CNT_W'(alle_pkg::Q_DEPTH));
  assign empty      = (cnt_q == '0);
  assign wr_en      = res_push_i && !res_full_o;
  assign rd_en      = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + alle_pkg::Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + alle_pkg::Q_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + alle_pkg::Q_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - alle_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

  // Oldest result on the ports
  assign head            = entry_q[rd_ptr_q];
  assign status_o        = head.status;
  assign node_index_o    = head.idx;
  assign element_count_o = head.count;

endmodule
`default_nettype wire

FILE: rtl/array_linked_list_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// array_linked_list_engine_core: linked list over a fixed node pool
// Insert at head, delete head and search by value over one list with a
// free list threaded through the same link store.
//
//   channel  handshake     fields
//   command  push / full   cmd_i, data_value_i
//   result   pop / empty   status_o, node_index_o, element_count_o
//
// Insert and delete read the link store in idle and finish in BK_INS or
// BK_DEL; search walks the list node by node, up to NODE_COUNT nodes, paced
// by the single registered read port of the link and value stores.
// A command is written into the intake queue before the engine sees it.
// The engine stalls when the result queue is full; intake keeps taking
// commands until its own queue fills. Reset leaves both queues empty and
// the pool ready at once (no clearing pass).
// ----------------------------------------------------------------------------
module array_linked_list_engine_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             push,
  output logic                            full,
  input  wire  [alle_pkg::CMD_W-1:0]      cmd_i,
  input  wire  [alle_pkg::DATA_W-1:0]     data_value_i,
  output logic                            empty,
  input  wire                             pop,
  output logic [alle_pkg::STATUS_W-1:0]   status_o,
  output logic [alle_pkg::IDX_W-1:0]      node_index_o,
  output logic [alle_pkg::CNT_W-1:0]      element_count_o
);

  alle_pkg::fe_req_t req;
  alle_pkg::res_t    res;
  logic              take;
  logic              res_push;
  logic              res_full;

  // Command intake
  alle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cmd_i        (cmd_i),
    .data_value_i (data_value_i),
    .req_o        (req),
    .take_i       (take)
  );

  // List engine
  alle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .take_o     (take),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // Result queue
  alle_result_q u_result_q (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_push_i      (res_push),
    .res_i           (res),
    .res_full_o      (res_full),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .node_index_o    (node_index_o),
    .element_count_o (element_count_o)
  );

endmodule
`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for array_linked_list_engine_core
// Drives insert, delete, search and undefined commands through the command
// queue and predicts each result from a local copy of the node pool, link
// store, list head, free head and element count. Results are compared field
// by field in order. A directed opening covers empty, full and duplicate
// cases. Random bursts that lean toward inserts or deletes follow, so the
// pool fills and drains many times. The sender and receiver idle at random
// rates that change between phases.
// ----------------------------------------------------------------------------
module tb;

  // Model of the list engine plus the queue of outstanding results
  class list_scoreboard;
    logic [alle_pkg::VALUE_WIDTH-1:0] node_val [alle_pkg::NODE_COUNT];
    logic [alle_pkg::LINK_W-1:0]      node_link [alle_pkg::NODE_COUNT];
    logic [alle_pkg::LINK_W-1:0]      head;
    logic [alle_pkg::LINK_W-1:0]      free_head;
    logic [alle_pkg::CNT_W-1:0]       live;
    alle_pkg::res_t                   awaited [$];
    int                               errors;

    function new();
      errors    = 0;
      head      = alle_pkg::NULL_LINK;
      free_head = '0;
      live      = '0;
      for (int i = 0; i < alle_pkg::NODE_COUNT; i++) begin
        node_val[i]  = '0;
        node_link[i] = alle_pkg::LINK_W'(i + 1);
      end
    endfunction

    // Apply one accepted command transfer and queue its result
    function void note_input(alle_pkg::cmd_e c, logic [alle_pkg::DATA_W-1:0] d);
      alle_pkg::res_t                   r;
      logic [alle_pkg::VALUE_WIDTH-1:0] v;
      logic [alle_pkg::LINK_W-1:0]      n;
      logic                             hit;
      v        = alle_pkg::VALUE_WIDTH'($signed(d));
      r.status = alle_pkg::ST_OK;
      r.idx    = '0;
      case (c)
        alle_pkg::CMD_INSERT: begin
          if (free_head >= alle_pkg::NULL_LINK) begin
            r.status = alle_pkg::ST_OVERFLOW;
          end else begin
            n         = free_head;
            free_head = node_link[n[alle_pkg::IDX_W-1:0]];
            node_val[n[alle_pkg::IDX_W-1:0]]  = v;
            node_link[n[alle_pkg::IDX_W-1:0]] = head;
            head  = n;
            live  = live + 1'b1;
            r.idx = n[alle_pkg::IDX_W-1:0];
          end
        end
        alle_pkg::CMD_DELETE: begin
          if (head >= alle_pkg::NULL_LINK) begin
            r.status = alle_pkg::ST_UNDERFLOW;
          end else begin
            n    = head;
            head = node_link[n[alle_pkg::IDX_W-1:0]];
            node_link[n[alle_pkg::IDX_W-1:0]] = free_head;
            free_head = n;
            if (live != 0) live = live - 1'b1;
            r.idx = n[alle_pkg::IDX_W-1:0];
          end
        end
        alle_pkg::CMD_SEARCH: begin
          // first match from the head wins; bounded walk
          n   = head;
          hit = 1'b0;
          for (int s = 0; s < alle_pkg::NODE_COUNT && n < alle_pkg::NULL_LINK && !hit;
               s++) begin
            if (node_val[n[alle_pkg::IDX_W-1:0]] == v) begin
              hit   = 1'b1;
              r.idx = n[alle_pkg::IDX_W-1:0];
            end else begin
              n = node_link[n[alle_pkg::IDX_W-1:0]];
            end
          end
          if (!hit) r.status = alle_pkg::ST_NOTFOUND;
        end
        default: ;  // undefined command: no change, ok, index zero
      endcase
      r.count = live;
      awaited.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted result transfer with the oldest expectation
    task check_result(logic [alle_pkg::STATUS_W-1:0] st, logic [alle_pkg::IDX_W-1:0] ix,
                      logic [alle_pkg::CNT_W-1:0] ct);
      alle_pkg::res_t e;
      if (awaited.size() == 0) begin
        report("result transfer with nothing outstanding");
      end else begin
        e = awaited.pop_front();
        if (st !== e.status)
          report($sformatf("status got %0d exp %0d", st, e.status));
        if (ix !== e.idx)
          report($sformatf("node_index got %0d exp %0d", ix, e.idx));
        if (ct !== e.count)
          report($sformatf("element_count got %0d exp %0d", ct, e.count));
      end
    endtask
  endclass

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            push         = 1'b0;
  logic                            pop          = 1'b0;
  logic [alle_pkg::CMD_W-1:0]      cmd_i        = '0;
  logic [alle_pkg::DATA_W-1:0]     data_value_i = '0;
  logic                            full;
  logic                            empty;
  logic [alle_pkg::STATUS_W-1:0]   status_o;
  logic [alle_pkg::IDX_W-1:0]      node_index_o;
  logic [alle_pkg::CNT_W-1:0]      element_count_o;

  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;
  list_scoreboard        sb = new();

  array_linked_list_engine_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .cmd_i           (cmd_i),
    .data_value_i    (data_value_i),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .node_index_o    (node_index_o),
    .element_count_o (element_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: random stalls on pop
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Transfer monitor: sees pre-edge values of both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_input(alle_pkg::cmd_e'(cmd_i), data_value_i);
      if (pop && !empty) sb.check_result(status_o, node_index_o, element_count_o);
    end
  end

  // Offer one command; returns after the edge that accepts it
  task automatic send_item(alle_pkg::cmd_e c, logic [alle_pkg::DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    cmd_i        <= c;
    data_value_i <= d;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Random bursts leaning toward inserts or deletes
  task automatic run_random(int n_items);
    int                          left;
    int                          burst;
    bit                          grow;
    int unsigned                 roll;
    alle_pkg::cmd_e              c;
    logic [alle_pkg::DATA_W-1:0] d;
    logic [alle_pkg::LINK_W-1:0] n;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(40, 8);
      grow  = $urandom_range(1);
      while (burst > 0 && left > 0) begin
        roll = $urandom_range(99);
        if (roll < 4)                      c = alle_pkg::CMD_UNDEF;
        else if (roll < 28)                c = alle_pkg::CMD_SEARCH;
        else if ((roll < 75) == grow)      c = alle_pkg::CMD_INSERT;
        else                               c = alle_pkg::CMD_DELETE;
        // data: mostly full random, some extremes and small repeated values
        case ($urandom_range(7))
          0:       d = 32'h8000_0000;
          1:       d = 32'h7FFF_FFFF;
          2:       d = 32'hFFFF_FFFF;
          3:       d = alle_pkg::DATA_W'($urandom_range(3));
          default: d = $urandom;
        endcase
        // searches mostly target a value held somewhere in the list
        if (c == alle_pkg::CMD_SEARCH && sb.live != 0 && $urandom_range(9) < 6) begin
          n = sb.head;
          repeat ($urandom_range(sb.live - 1)) begin
            if (n < alle_pkg::NULL_LINK) n = sb.node_link[n[alle_pkg::IDX_W-1:0]];
          end
          if (n < alle_pkg::NULL_LINK) d = sb.node_val[n[alle_pkg::IDX_W-1:0]];
        end
        send_item(c, d);
        left--;
        burst--;
      end
    end
  endtask

  // Hard stop
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, extremes, duplicates, full pool
    send_idle_pct = 16;
    recv_idle_pct = 51;
    send_item(alle_pkg::CMD_UNDEF,  32'hFFFF_FFFF);
    send_item(alle_pkg::CMD_DELETE, 32'h0000_0000);
    send_item(alle_pkg::CMD_SEARCH, 32'h0000_0000);
    send_item(alle_pkg::CMD_INSERT, 32'h8000_0000);
    send_item(alle_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_item(alle_pkg::CMD_INSERT, 32'h0000_0000);
    send_item(alle_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_item(alle_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_item(alle_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
    send_item(alle_pkg::CMD_SEARCH, 32'h8000_0000);
    send_item(alle_pkg::CMD_SEARCH, 32'h5A5A_5A5A);
    send_item(alle_pkg::CMD_UNDEF,  32'h1234_5678);
    send_item(alle_pkg::CMD_DELETE, 32'hFFFF_FFFF);
    send_item(alle_pkg::CMD_DELETE, 32'h0000_0000);
    send_item(alle_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
    // fill the pool, then overflow and a full-length walk to the tail
    for (int i = 0; i < alle_pkg::NODE_COUNT - 3; i++) begin
      send_item(alle_pkg::CMD_INSERT, $urandom);
    end
    send_item(alle_pkg::CMD_INSERT, 32'h0000_0001);
    send_item(alle_pkg::CMD_SEARCH, 32'h8000_0000);
    send_item(alle_pkg::CMD_SEARCH, 32'h0BAD_0BAD);

    // Random phases with changing idle rates
    run_random(233);
    send_idle_pct = 51;
    recv_idle_pct = 16;
    run_random(233);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(234);
    push <= 1'b0;

    // Drain
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
